/* design/sd_spi_init_and_block_read_top_assert.svh */
// Assertion macros for the SD SPI master.
`ifndef SD_SPI_INIT_AND_BLOCK_READ_TOP_ASSERT_SVH
`define SD_SPI_INIT_AND_BLOCK_READ_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/sds_pkg.sv */
// Package: types, codes and frame constants for the SD SPI master.
`default_nettype none
package sds_pkg;
  localparam int unsigned BlockBytesDef = 512;
  localparam logic [7:0] WakeRst  = 8'd16;
  localparam logic [7:0] PollRst  = 8'd32;
  localparam logic [7:0] RetryRst = 8'd255;
  localparam logic [7:0] TokenRst = 8'd255;

  localparam logic [1:0] CmdInit = 2'd0;
  localparam logic [1:0] CmdRead = 2'd1;
  localparam logic [1:0] CmdRx   = 2'd2;

  localparam logic [1:0] RegWake  = 2'd0;
  localparam logic [1:0] RegPoll  = 2'd1;
  localparam logic [1:0] RegRetry = 2'd2;
  localparam logic [1:0] RegToken = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StCmd0To  = 3'd1;
  localparam logic [2:0] StAcmdTo  = 3'd2;
  localparam logic [2:0] StOcrErr  = 3'd3;
  localparam logic [2:0] StMmc     = 3'd4;
  localparam logic [2:0] StR1Err   = 3'd5;
  localparam logic [2:0] StTokenTo = 3'd6;

  localparam logic [3:0] PosPoll = 4'd6;
  localparam logic [3:0] PosTail = 4'd7;

  typedef enum logic [15:0] {
    PH_IDLE   = 16'h0001,
    PH_WAKE   = 16'h0002,
    PH_GAP    = 16'h0004,
    PH_CMD0   = 16'h0008,
    PH_CMD8   = 16'h0010,
    PH_V2_55  = 16'h0020,
    PH_V2_41  = 16'h0040,
    PH_V1P_55 = 16'h0080,
    PH_V1P_41 = 16'h0100,
    PH_V1_55  = 16'h0200,
    PH_V1_41  = 16'h0400,
    PH_CMD58  = 16'h0800,
    PH_CMD17  = 16'h1000,
    PH_TOKEN  = 16'h2000,
    PH_DATA   = 16'h4000,
    PH_TRAIL  = 16'h8000
  } phase_e;

  typedef struct packed {
    logic [7:0] wake;
    logic [7:0] poll;
    logic [7:0] retry;
    logic [7:0] token;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       fast_clock;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [2:0] status;
  } res_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] sector;
    logic [7:0]  rx_byte;
  } item_t;

  // Command frame byte i (0..5) for a command phase.
  function automatic logic [7:0] frame_byte(phase_e p, logic [2:0] i, logic [31:0] addr);
    logic [7:0] op;
    logic [7:0] crc;
    logic [7:0] arg;
    begin
      crc = 8'hFF;
      case (p)
        PH_CMD0: begin op = 8'h40; crc = 8'h95; end
        PH_CMD8: begin op = 8'h48; crc = 8'h87; end
        PH_V2_55, PH_V1P_55, PH_V1_55: op = 8'h77;
        PH_V2_41, PH_V1P_41, PH_V1_41: op = 8'h69;
        PH_CMD58: op = 8'h7A;
        default: op = 8'h51;
      endcase
      arg = 8'h00;
      if (p == PH_CMD8) begin
        arg = (i == 3'd3) ? 8'h01 : ((i == 3'd4) ? 8'hAA : 8'h00);
      end else if (p == PH_V2_41) begin
        arg = (i == 3'd1) ? 8'h40 : 8'h00;
      end else if (p == PH_CMD17) begin
        case (i)
          3'd1: arg = addr[31:24];
          3'd2: arg = addr[23:16];
          3'd3: arg = addr[15:8];
          default: arg = addr[7:0];
        endcase
      end
      if (i == 3'd0) frame_byte = op;
      else if (i >= 3'd5) frame_byte = crc;
      else frame_byte = arg;
    end
  endfunction
endpackage
`default_nettype wire

/* design/sds_cfg_regs.sv */
// Configuration register file for the SD SPI master.
`default_nettype none
module sds_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  output sds_pkg::cfg_t      cfg_o
);
  sds_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wake  <= sds_pkg::WakeRst;
      cfg_q.poll  <= sds_pkg::PollRst;
      cfg_q.retry <= sds_pkg::RetryRst;
      cfg_q.token <= sds_pkg::TokenRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sds_pkg::RegWake:  cfg_q.wake  <= cfg_data_i;
        sds_pkg::RegPoll:  cfg_q.poll  <= cfg_data_i;
        sds_pkg::RegRetry: cfg_q.retry <= cfg_data_i;
        sds_pkg::RegToken: cfg_q.token <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

/* design/sds_seq.sv */
// Sequencer: state registers and one-step next-state / result logic.
`default_nettype none
module sds_seq #(
  parameter int unsigned BlockBytes = sds_pkg::BlockBytesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  sds_pkg::item_t     item_i,
  input  sds_pkg::cfg_t      cfg_i,
  output sds_pkg::res_t      res_o
);
  // the counter also holds wake bytes (up to 255) and frame positions
  localparam int unsigned CntW = (BlockBytes > 256) ? $clog2(BlockBytes) : 8;
  localparam logic [CntW:0] LastData = (CntW + 1)'(BlockBytes - 1);

  sds_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      poll_q, poll_d, retry_q, retry_d;
  logic [31:0]     addr_q, addr_d;
  logic            v2_q, v2_d, cs_q, cs_d, fast_q, fast_d;
  sds_pkg::res_t   r;
  logic [8:0]      poll_inc;
  logic [3:0]      pos;
  logic [7:0]      rx;

  assign rx  = item_i.rx_byte;
  assign pos = cnt_q[3:0];
  assign poll_inc = {1'b0, poll_q} + 9'd1;

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; poll_d = poll_q; retry_d = retry_q;
    addr_d = addr_q; v2_d = v2_q; cs_d = cs_q; fast_d = fast_q;
    r = '0;
    case (item_i.cmd)
      sds_pkg::CmdInit: begin
        cs_d = 1'b1; fast_d = 1'b0; v2_d = 1'b0; retry_d = '0; poll_d = '0; cnt_d = '0;
        if (cfg_i.wake == 8'd0) begin
          phase_d = sds_pkg::PH_GAP; cs_d = 1'b0;
        end else begin
          phase_d = sds_pkg::PH_WAKE;
        end
        r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
      end
      sds_pkg::CmdRead: begin
        addr_d = {item_i.sector[22:0], 9'd0};
        cs_d = 1'b1; retry_d = '0; poll_d = '0;
        phase_d = sds_pkg::PH_CMD17; cnt_d = '0;
        r.tx_valid = 1'b1; r.tx_byte = 8'h51;
      end
      sds_pkg::CmdRx: begin
        case (phase_q)
          sds_pkg::PH_IDLE: ;
          sds_pkg::PH_WAKE: begin
            r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            if ({1'b0, cnt_q[7:0]} + 9'd1 >= {1'b0, cfg_i.wake}) begin
              phase_d = sds_pkg::PH_GAP; cnt_d = '0; cs_d = 1'b0;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          sds_pkg::PH_GAP: begin
            r.tx_valid = 1'b1;
            if (cnt_q != '0) begin
              cs_d = 1'b1; retry_d = '0; phase_d = sds_pkg::PH_CMD0; cnt_d = '0;
              r.tx_byte = 8'h40;
            end else begin
              cnt_d = cnt_q + 1'b1; r.tx_byte = 8'hFF;
            end
          end
          sds_pkg::PH_TOKEN: begin
            if (rx == 8'hFE) begin
              phase_d = sds_pkg::PH_DATA; cnt_d = '0;
              r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            end else if (retry_q >= cfg_i.token) begin
              cs_d = 1'b0; phase_d = sds_pkg::PH_IDLE;
              r.done_res = 1'b1; r.status = sds_pkg::StTokenTo;
            end else begin
              retry_d = retry_q + 8'd1;
              r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            end
          end
          sds_pkg::PH_DATA: begin
            r.data_valid = 1'b1; r.data_byte = rx;
            r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            if ({1'b0, cnt_q} >= LastData) begin
              phase_d = sds_pkg::PH_TRAIL; cnt_d = '0;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          sds_pkg::PH_TRAIL: begin
            if (cnt_q >= CntW'(2)) begin
              cs_d = 1'b0; phase_d = sds_pkg::PH_IDLE;
              r.done_res = 1'b1; r.status = sds_pkg::StOk;
            end else begin
              cnt_d = cnt_q + 1'b1; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            end
          end
          default: begin
            r.tx_valid = 1'b1;
            if (pos < 4'd5) begin
              cnt_d = CntW'(pos + 4'd1);
              r.tx_byte = sds_pkg::frame_byte(phase_q, 3'(pos + 4'd1), addr_q);
            end else if (pos == 4'd5) begin
              cnt_d = CntW'(sds_pkg::PosPoll); poll_d = '0; r.tx_byte = 8'hFF;
            end else if (pos == sds_pkg::PosPoll) begin
              poll_d = poll_inc[7:0];
              if (!rx[7] || poll_inc >= {1'b0, cfg_i.poll}) begin
                // R1 handling
                r.tx_valid = 1'b0;
                case (phase_q)
                  sds_pkg::PH_CMD0: begin
                    if (rx == 8'd1) begin
                      phase_d = sds_pkg::PH_CMD8; cnt_d = '0;
                      r.tx_valid = 1'b1; r.tx_byte = 8'h48;
                    end else if (retry_q >= cfg_i.retry) begin
                      cs_d = 1'b0; phase_d = sds_pkg::PH_IDLE;
                      r.done_res = 1'b1; r.status = sds_pkg::StCmd0To;
                    end else begin
                      retry_d = retry_q + 8'd1; cnt_d = '0;
                      r.tx_valid = 1'b1; r.tx_byte = 8'h40;
                    end
                  end
                  sds_pkg::PH_CMD8, sds_pkg::PH_CMD58: begin
                    if (phase_q == sds_pkg::PH_CMD8) v2_d = (rx == 8'd1);
                    poll_d = rx; cnt_d = CntW'(sds_pkg::PosTail);
                    r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
                  end
                  sds_pkg::PH_V2_55, sds_pkg::PH_V1P_55, sds_pkg::PH_V1_55: begin
                    phase_d = (phase_q == sds_pkg::PH_V2_55) ? sds_pkg::PH_V2_41 :
                              (phase_q == sds_pkg::PH_V1P_55) ? sds_pkg::PH_V1P_41 :
                              sds_pkg::PH_V1_41;
                    cnt_d = '0; r.tx_valid = 1'b1; r.tx_byte = 8'h69;
                  end
                  sds_pkg::PH_V2_41, sds_pkg::PH_V1_41: begin
                    if (!rx[0]) begin
                      if (phase_q == sds_pkg::PH_V2_41) begin
                        phase_d = sds_pkg::PH_CMD58; cnt_d = '0;
                        r.tx_valid = 1'b1; r.tx_byte = 8'h7A;
                      end else begin
                        cs_d = 1'b0; fast_d = 1'b1; phase_d = sds_pkg::PH_IDLE;
                        r.done_res = 1'b1; r.status = sds_pkg::StOk;
                      end
                    end else if (retry_q >= cfg_i.retry) begin
                      cs_d = 1'b0; phase_d = sds_pkg::PH_IDLE;
                      r.done_res = 1'b1; r.status = sds_pkg::StAcmdTo;
                    end else begin
                      retry_d = retry_q + 8'd1; cnt_d = '0;
                      phase_d = (phase_q == sds_pkg::PH_V2_41) ? sds_pkg::PH_V2_55 :
                                sds_pkg::PH_V1_55;
                      r.tx_valid = 1'b1; r.tx_byte = 8'h77;
                    end
                  end
                  sds_pkg::PH_V1P_41: begin
                    if (rx <= 8'd1) begin
                      retry_d = '0; phase_d = sds_pkg::PH_V1_55; cnt_d = '0;
                      r.tx_valid = 1'b1; r.tx_byte = 8'h77;
                    end else begin
                      cs_d = 1'b0; phase_d = sds_pkg::PH_IDLE;
                      r.done_res = 1'b1; r.status = sds_pkg::StMmc;
                    end
                  end
                  default: begin
                    if (rx[7]) begin
                      cs_d = 1'b0; phase_d = sds_pkg::PH_IDLE;
                      r.done_res = 1'b1; r.status = sds_pkg::StR1Err;
                    end else begin
                      phase_d = sds_pkg::PH_TOKEN; retry_d = '0;
                      r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
                    end
                  end
                endcase
              end else begin
                r.tx_byte = 8'hFF;
              end
            end else begin
              // response tail: five bytes after CMD8, four after CMD58
              if ((phase_q == sds_pkg::PH_CMD8 && pos >= 4'd11) ||
                  (phase_q != sds_pkg::PH_CMD8 && pos >= 4'd10)) begin
                if (phase_q == sds_pkg::PH_CMD8) begin
                  retry_d = '0; cnt_d = '0;
                  phase_d = v2_q ? sds_pkg::PH_V2_55 : sds_pkg::PH_V1P_55;
                  r.tx_byte = 8'h77;
                end else begin
                  r.tx_valid = 1'b0; cs_d = 1'b0; phase_d = sds_pkg::PH_IDLE;
                  r.done_res = 1'b1;
                  if (poll_q != 8'd0) begin
                    r.status = sds_pkg::StOcrErr;
                  end else begin
                    fast_d = 1'b1; r.status = sds_pkg::StOk;
                  end
                end
              end else begin
                cnt_d = cnt_q + 1'b1; r.tx_byte = 8'hFF;
              end
            end
          end
        endcase
      end
      default: ;
    endcase
    r.cs_active  = cs_d;
    r.fast_clock = fast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sds_pkg::PH_IDLE; cnt_q <= '0; poll_q <= '0; retry_q <= '0;
      addr_q <= '0; v2_q <= 1'b0; cs_q <= 1'b0; fast_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; cnt_q <= cnt_d; poll_q <= poll_d; retry_q <= retry_d;
      addr_q <= addr_d; v2_q <= v2_d; cs_q <= cs_d; fast_q <= fast_d;
    end
  end

  assign res_o = r;
endmodule
`default_nettype wire

/* design/sds_out_reg.sv */
// Output register with a skid stage on the result stream.
`default_nettype none
module sds_out_reg (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  sds_pkg::res_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output sds_pkg::res_t  out_data_o
);
  logic          main_v_q, skid_v_q;
  sds_pkg::res_t main_q, skid_q;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0; skid_v_q <= 1'b0;
    end else begin
      if (!main_v_q || out_ready_i) begin
        main_v_q <= skid_v_q || in_valid_i;
        skid_v_q <= 1'b0;
      end else if (in_valid_i && !skid_v_q) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_v_q || out_ready_i) begin
      main_q <= skid_v_q ? skid_q : in_data_i;
    end
    if (!skid_v_q) skid_q <= in_data_i;
  end
endmodule
`default_nettype wire

/* design/sd_spi_init_and_block_read_top.sv */
// SD card SPI-mode master: init and single-block read sequencer, top level.
// Usage:
//   s_axis carries one item per transfer: tdata = {rx_byte, sector}, tuser = cmd.
//   cmd 0 starts init, cmd 1 starts a sector read, cmd 2 returns the byte
//   clocked in by the previous exchange. Each item yields exactly one result
//   on m_axis: the next SPI byte (tx_valid/tx_byte), chip-select and clock
//   speed, a payload byte when one arrived, and done/status at the end.
//   Registers (wake_bytes, r1_poll_limit, retry_limit, token_limit) are written on the
//   cfg channel at index 0..3; the user must write them only while the block is idle, as the block does not enforce it.
// Throughput: one item per cycle while m_axis does not stall, set by the single
//   sequencer step between the state registers and the output register; the
//   result of each input transfer is registered before it appears on m_axis.
// Reset: sequencer idle, chip select released, slow clock, registers at
//   their defaults. When m_axis stalls, one result is held in the output
//   register and one in the skid stage; s_axis_tready drops only then.
`default_nettype none
module sd_spi_init_and_block_read_top #(
  parameter int unsigned BlockBytes = sds_pkg::BlockBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [31:0] sector, [39:32] rx_byte
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // tx_valid, tx_byte, cs_active, fast_clock,
                                          // data_valid, data_byte, done_res, status
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  sds_pkg::cfg_t  cfg;
  sds_pkg::item_t item;
  sds_pkg::res_t  res, res_out;
  logic           step;

  assign cfg_ready_o = 1'b1;
  assign step = s_axis_tvalid && s_axis_tready;
  assign item.cmd = s_axis_tuser;
  assign item.sector = s_axis_tdata[31:0];
  assign item.rx_byte = s_axis_tdata[39:32];

  sds_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  sds_seq #(.BlockBytes(BlockBytes)) u_seq (
    .clk_i, .rst_ni, .step_i(step), .item_i(item), .cfg_i(cfg), .res_o(res)
  );

  sds_out_reg u_out (
    .clk_i, .rst_ni, .in_valid_i(step), .in_ready_o(s_axis_tready), .in_data_i(res),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res_out)
  );

  assign m_axis_tdata = {res_out.status, res_out.done_res, res_out.data_byte,
                         res_out.data_valid, res_out.fast_clock, res_out.cs_active,
                         res_out.tx_byte, res_out.tx_valid};

`include "sd_spi_init_and_block_read_top_assert.svh"

  `SDS_ASSERT_IMP(a_done_no_tx, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[20], !m_axis_tdata[0], "done with tx")
  `SDS_ASSERT_IMP(a_data_has_tx, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[11], m_axis_tdata[0], "payload without tx")
  `SDS_ASSERT_NEXT(a_step_gives_out, clk_i, rst_ni, step, m_axis_tvalid, "result lost")
endmodule
`default_nettype wire

/* sim/tb_sd_spi_init_and_block_read_top.sv */
// Testbench for the SD SPI init and block-read sequencer, with card emulation and predictor.
`timescale 1ns / 1ps
module tb_sd_spi_init_and_block_read_top;
  import sds_pkg::*;

  localparam logic [1:0] CmdNone = 2'd3;

  typedef enum int {
    CARD_V2, CARD_V1, CARD_MMC, CARD_DEAD, CARD_BUSY, CARD_BAD_OCR
  } card_e;

  typedef struct {
    phase_e      phase;
    int unsigned bcount;
    int unsigned polls;
    int unsigned retries;
    logic [31:0] addr;
    bit          v2;
    bit          cs;
    bit          fast;
  } seq_t;

  typedef struct {
    bit         txv;
    logic [7:0] tx;
    bit         cs;
    bit         fast;
    bit         dv;
    logic [7:0] db;
    bit         done;
    logic [2:0] st;
  } exch_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] sector;
    logic [7:0]  rx;
  } spi_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  sd_spi_init_and_block_read_top uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cfg_t      live_cfg = '{WakeRst, PollRst, RetryRst, TokenRst};
  cfg_t      plan_cfg = '{WakeRst, PollRst, RetryRst, TokenRst};
  seq_t      dut_seq;
  seq_t      plan_seq;
  exch_t     plan_out;
  exch_t     accepted_exch;
  exch_t     expected_exch[$];
  spi_item_t pending_items[$];
  int        errors = 0;
  int        planned = 0;
  bit        quiet = 1'b0;
  bit        took = 1'b0;
  int        src_gap = 0;
  int        snk_gap = 0;
  card_e     card_kind;
  bit        bad_r1;
  bit        no_token;

  function automatic seq_t seq_reset();
    seq_t s;
    s.phase = PH_IDLE; s.bcount = 0; s.polls = 0; s.retries = 0;
    s.addr = '0; s.v2 = 0; s.cs = 0; s.fast = 0;
    return s;
  endfunction

  function automatic logic [7:0] frame_at(phase_e p, int unsigned i, logic [31:0] a);
    logic [7:0] op;
    logic [7:0] crc;
    crc = 8'hFF;
    case (p)
      PH_CMD0: begin op = 8'h40; crc = 8'h95; end
      PH_CMD8: begin op = 8'h48; crc = 8'h87; end
      PH_V2_55, PH_V1P_55, PH_V1_55: op = 8'h77;
      PH_V2_41, PH_V1P_41, PH_V1_41: op = 8'h69;
      PH_CMD58: op = 8'h7A;
      default: op = 8'h51;
    endcase
    if (i == 0) return op;
    if (i >= 5) return crc;
    if (p == PH_CMD8) return (i == 3) ? 8'h01 : ((i == 4) ? 8'hAA : 8'h00);
    if (p == PH_V2_41) return (i == 1) ? 8'h40 : 8'h00;
    if (p == PH_CMD17) return 8'(a >> (8 * (4 - i)));
    return 8'h00;
  endfunction

  function automatic void send(inout exch_t o, input logic [7:0] b);
    o.txv = 1; o.tx = b;
  endfunction

  function automatic void open_cmd(inout seq_t s, inout exch_t o, input phase_e p);
    s.phase = p;
    s.bcount = 0;
    send(o, frame_at(p, 0, s.addr));
  endfunction

  function automatic void close_op(inout seq_t s, inout exch_t o, input logic [2:0] code);
    s.cs = 0; s.phase = PH_IDLE; o.done = 1; o.st = code;
  endfunction

  function automatic void init_ok(inout seq_t s, inout exch_t o);
    s.cs = 0; s.fast = 1; s.phase = PH_IDLE; o.done = 1; o.st = StOk;
  endfunction

  function automatic void retry_cmd(inout seq_t s, inout exch_t o, input cfg_t c,
                                    input phase_e again, input logic [2:0] code);
    if (s.retries >= c.retry) close_op(s, o, code);
    else begin
      s.retries++;
      open_cmd(s, o, again);
    end
  endfunction

  function automatic void r1_resp(inout seq_t s, inout exch_t o, input cfg_t c,
                                  input logic [7:0] r);
    case (s.phase)
      PH_CMD0: if (r == 8'h01) open_cmd(s, o, PH_CMD8);
               else retry_cmd(s, o, c, PH_CMD0, StCmd0To);
      PH_CMD8, PH_CMD58: begin
        if (s.phase == PH_CMD8) s.v2 = (r == 8'h01);
        s.polls = r; s.bcount = PosTail; send(o, 8'hFF);
      end
      PH_V2_55: open_cmd(s, o, PH_V2_41);
      PH_V1P_55: open_cmd(s, o, PH_V1P_41);
      PH_V1_55: open_cmd(s, o, PH_V1_41);
      PH_V2_41: if (!r[0]) open_cmd(s, o, PH_CMD58);
                else retry_cmd(s, o, c, PH_V2_55, StAcmdTo);
      PH_V1P_41: if (r <= 8'h01) begin
                   s.retries = 0;
                   open_cmd(s, o, PH_V1_55);
                 end else close_op(s, o, StMmc);
      PH_V1_41: if (!r[0]) init_ok(s, o);
                else retry_cmd(s, o, c, PH_V1_55, StAcmdTo);
      default: if (r[7]) close_op(s, o, StR1Err);
               else begin
                 s.phase = PH_TOKEN; s.retries = 0; send(o, 8'hFF);
               end
    endcase
  endfunction

  function automatic void frame_rx(inout seq_t s, inout exch_t o, input cfg_t c,
                                   input logic [7:0] rx);
    int unsigned len;
    if (s.bcount < 5) begin
      s.bcount++;
      send(o, frame_at(s.phase, s.bcount, s.addr));
    end else if (s.bcount == 5) begin
      s.bcount = PosPoll; s.polls = 0; send(o, 8'hFF);
    end else if (s.bcount == PosPoll) begin
      s.polls++;
      if (!rx[7] || s.polls >= c.poll) r1_resp(s, o, c, rx);
      else send(o, 8'hFF);
    end else begin
      len = (s.phase == PH_CMD8) ? 5 : 4;
      if (s.bcount - PosTail + 1 >= len) begin
        if (s.phase == PH_CMD8) begin
          s.retries = 0;
          open_cmd(s, o, s.v2 ? PH_V2_55 : PH_V1P_55);
        end else if (s.polls != 0) close_op(s, o, StOcrErr);
        else init_ok(s, o);
      end else begin
        s.bcount++; send(o, 8'hFF);
      end
    end
  endfunction

  // One sequencer step: next exchange, line levels and completion for one item.
  function automatic exch_t seq_step(inout seq_t s, input cfg_t c, input spi_item_t it);
    exch_t o;
    o = '{0, 8'h00, 0, 0, 0, 8'h00, 0, 3'd0};
    if (it.cmd == CmdInit) begin
      s.cs = 1; s.fast = 0; s.v2 = 0; s.retries = 0; s.polls = 0; s.bcount = 0;
      if (c.wake == 0) begin
        s.phase = PH_GAP; s.cs = 0;
      end else s.phase = PH_WAKE;
      send(o, 8'hFF);
    end else if (it.cmd == CmdRead) begin
      s.addr = {it.sector[22:0], 9'd0};
      s.cs = 1; s.retries = 0; s.polls = 0;
      open_cmd(s, o, PH_CMD17);
    end else if (it.cmd == CmdRx) begin
      case (s.phase)
        PH_IDLE: ;
        PH_WAKE: begin
          s.bcount++;
          if (s.bcount >= c.wake) begin
            s.phase = PH_GAP; s.bcount = 0; s.cs = 0;
          end
          send(o, 8'hFF);
        end
        PH_GAP: if (s.bcount + 1 >= 2) begin
                  s.cs = 1; s.retries = 0; open_cmd(s, o, PH_CMD0);
                end else begin
                  s.bcount++; send(o, 8'hFF);
                end
        PH_TOKEN: if (it.rx == 8'hFE) begin
                    s.phase = PH_DATA; s.bcount = 0; send(o, 8'hFF);
                  end else if (s.retries >= c.token) close_op(s, o, StTokenTo);
                  else begin
                    s.retries++; send(o, 8'hFF);
                  end
        PH_DATA: begin
          o.dv = 1; o.db = it.rx;
          if (s.bcount + 1 >= BlockBytesDef) begin
            s.phase = PH_TRAIL; s.bcount = 0;
          end else s.bcount++;
          send(o, 8'hFF);
        end
        PH_TRAIL: if (s.bcount + 1 >= 3) close_op(s, o, StOk);
                  else begin
                    s.bcount++; send(o, 8'hFF);
                  end
        default: frame_rx(s, o, c, it.rx);
      endcase
    end
    o.cs = s.cs;
    o.fast = s.fast;
    return o;
  endfunction

  // Queue an item and step the planning copy so the card can answer in context.
  task automatic add(input logic [1:0] cmd, input logic [31:0] sec, input logic [7:0] rx);
    spi_item_t it;
    it = '{cmd, sec, rx};
    pending_items.push_back(it);
    plan_out = seq_step(plan_seq, plan_cfg, it);
    planned++;
  endtask

  function automatic logic [7:0] ok_or_busy();
    return ($urandom_range(0, 2) == 0) ? 8'h01 : 8'h00;
  endfunction

  // Card answer to the exchange just requested.
  function automatic logic [7:0] card_reply();
    logic [7:0] rnd;
    rnd = 8'($urandom);
    case (plan_seq.phase)
      PH_DATA: return rnd;
      PH_TOKEN: begin
        if (no_token) return ($urandom_range(0, 3) == 0) ? rnd & 8'hFD : 8'hFF;
        if ($urandom_range(0, 2) == 0) return 8'hFE;
        return ($urandom_range(0, 5) == 0) ? rnd : 8'hFF;
      end
      PH_WAKE, PH_GAP, PH_TRAIL, PH_IDLE: return rnd;
      default: ;
    endcase
    if (plan_seq.bcount != PosPoll) return rnd;
    if ($urandom_range(0, 2) == 0) return rnd | 8'h80;
    case (plan_seq.phase)
      PH_CMD0: return (card_kind == CARD_DEAD || $urandom_range(0, 4) == 0) ? 8'h00 : 8'h01;
      PH_CMD8: return (card_kind == CARD_V2 || card_kind == CARD_BAD_OCR) ? 8'h01 : 8'h05;
      PH_V2_41, PH_V1_41: return (card_kind == CARD_BUSY) ? 8'h01 : ok_or_busy();
      PH_V1P_41: return (card_kind == CARD_MMC) ? 8'h05 : ok_or_busy();
      PH_CMD58: return (card_kind == CARD_BAD_OCR) ? (rnd & 8'h7F) | 8'h01 : 8'h00;
      PH_CMD17: return bad_r1 ? rnd | 8'h80 : 8'h00;
      default: return 8'h01;
    endcase
  endfunction

  // One operation answered by the emulated card, cut short now and then.
  task automatic run_op(input bit is_read);
    int n;
    n = 0;
    card_kind = card_e'($urandom_range(0, 5));
    if (card_kind == CARD_DEAD || card_kind == CARD_BUSY)
      if ($urandom_range(0, 2) != 0) card_kind = CARD_V2;
    bad_r1 = ($urandom_range(0, 7) == 0);
    no_token = ($urandom_range(0, 7) == 0);
    if (is_read) add(CmdRead, $urandom, 8'($urandom));
    else add(CmdInit, $urandom, 8'($urandom));
    while (plan_out.txv && n < 20000) begin
      if ($urandom_range(0, 59) == 0) break;
      add(CmdRx, $urandom, card_reply());
      n++;
    end
  endtask

  task automatic noise();
    repeat ($urandom_range(0, 2))
      add(($urandom_range(0, 1) != 0) ? CmdRx : CmdNone, $urandom, 8'($urandom));
  endtask

  task automatic random_ops(input int target);
    int start;
    start = planned;
    while (planned - start < target) begin
      if ($urandom_range(0, 4) == 0) noise();
      run_op($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_exch.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegWake:  plan_cfg.wake = val;
      RegPoll:  plan_cfg.poll = val;
      RegRetry: plan_cfg.retry = val;
      default:  plan_cfg.token = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(RegWake, c.wake);
    write_reg(RegPoll, c.poll);
    write_reg(RegRetry, c.retry);
    write_reg(RegToken, c.token);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegWake:  live_cfg.wake <= cfg_data_i;
        RegPoll:  live_cfg.poll <= cfg_data_i;
        RegRetry: live_cfg.retry <= cfg_data_i;
        default:  live_cfg.token <= cfg_data_i;
      endcase
    end
  end

  // Predict on every input transfer.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      accepted_exch = seq_step(dut_seq, live_cfg,
                               '{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32]});
      expected_exch.push_back(accepted_exch);
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
  end

  // Source: hold the item until taken, with random idle bursts.
  always @(negedge clk_i) begin
    spi_item_t it;
    if (rst_ni && (!s_axis_tvalid || took)) begin
      if (!quiet && src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        src_gap <= $urandom_range(0, 8);
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.rx, it.sector};
        s_axis_tuser <= it.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random stall bursts on the result side.
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      m_axis_tready <= rst_ni;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      snk_gap <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    exch_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_exch.size() == 0) begin
        report("unexpected result", 32'(m_axis_tdata), 32'd0);
      end else begin
        w = expected_exch.pop_front();
        if (m_axis_tdata[0] !== w.txv)
          report("tx_valid", 32'(m_axis_tdata[0]), 32'(w.txv));
        if (m_axis_tdata[8:1] !== w.tx)
          report("tx_byte", 32'(m_axis_tdata[8:1]), 32'(w.tx));
        if (m_axis_tdata[9] !== w.cs)
          report("cs_active", 32'(m_axis_tdata[9]), 32'(w.cs));
        if (m_axis_tdata[10] !== w.fast)
          report("fast_clock", 32'(m_axis_tdata[10]), 32'(w.fast));
        if (m_axis_tdata[11] !== w.dv)
          report("data_valid", 32'(m_axis_tdata[11]), 32'(w.dv));
        if (m_axis_tdata[19:12] !== w.db)
          report("data_byte", 32'(m_axis_tdata[19:12]), 32'(w.db));
        if (m_axis_tdata[20] !== w.done)
          report("done_res", 32'(m_axis_tdata[20]), 32'(w.done));
        if (m_axis_tdata[23:21] !== w.st)
          report("status", 32'(m_axis_tdata[23:21]), 32'(w.st));
      end
    end
  end

  initial begin
    dut_seq = seq_reset();
    plan_seq = seq_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle noise, read before init at the top sector, aborts, then a clean init.
    add(CmdRx, 32'hFFFF_FFFF, 8'hFF);
    add(CmdNone, 32'h0, 8'h00);
    add(CmdRead, 32'hFFFF_FFFF, 8'h00);
    add(CmdRx, 32'h0, 8'hFF);
    add(CmdInit, 32'h0, 8'h00);
    add(CmdRx, 32'h0, 8'h00);
    add(CmdRead, 32'h0, 8'hFF);
    add(CmdNone, 32'hFFFF_FFFF, 8'hFF);
    wait_drained();
    write_all('{8'd1, 8'd1, 8'd0, 8'd0});
    add(CmdInit, 32'h0, 8'h00);
    card_kind = CARD_V2;
    bad_r1 = 0;
    no_token = 0;
    while (plan_out.txv) add(CmdRx, $urandom, card_reply());

    // Random part over several register settings, the extremes among them.
    wait_drained();
    write_all('{WakeRst, PollRst, RetryRst, TokenRst});
    random_ops(90);
    wait_drained();
    write_all('{8'd0, 8'd0, 8'd0, 8'd0});
    random_ops(90);
    wait_drained();
    write_all('{8'd255, 8'd255, 8'd255, 8'd255});
    random_ops(90);
    wait_drained();
    write_all('{8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)),
                8'($urandom_range(0, 5)), 8'($urandom_range(0, 10))});
    random_ops(70);
    wait_drained();
    quiet = 1'b1;
    random_ops(50);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("PASS sd_spi_init_and_block_read_top");
    else $display("FAIL sd_spi_init_and_block_read_top");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL sd_spi_init_and_block_read_top");
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/sds_pkg.sv
design/sds_cfg_regs.sv
design/sds_seq.sv
design/sds_out_reg.sv
design/sd_spi_init_and_block_read_top.sv
sim/tb_sd_spi_init_and_block_read_top.sv
